// ----- hdl/ibmw_pkg.sv -----
// ----------------------------------------------------------------------------
// Indirect block map walker package
// Shared types, codes and range arithmetic for the block map walker.
// ----------------------------------------------------------------------------
package ibmw_pkg;

  // Slot table layout: direct slots first, then the three indirect roots.
  localparam int DIRECT_SLOTS = 12;
  localparam int NUM_SLOTS    = DIRECT_SLOTS + 3 > 15 ? DIRECT_SLOTS + 3 : 15;
  localparam int SLOT_IDX_W   = $clog2(NUM_SLOTS);
  localparam int SINGLE_SLOT  = DIRECT_SLOTS;
  localparam int DOUBLE_SLOT  = DIRECT_SLOTS + 1;
  localparam int TRIPLE_SLOT  = DIRECT_SLOTS + 2;

  // Pointers per block are 256 shifted left by the block size setting.
  localparam int PTR_SHIFT_BASE = 8;
  localparam int LBS_MAX        = 2;
  localparam int WORD_IDX_W     = 10;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LOG_BLOCK_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ACT_TRANSLATE = 2'd0,
    ACT_RESPONSE  = 2'd1,
    ACT_LOAD_SLOT = 2'd2
  } action_t;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_FINAL   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_NULL  = 3'd2,
    ST_RDERR = 3'd3,
    ST_BUSY  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] logical_block;
    logic [3:0]  slot_index;
    logic [31:0] pointer_value;
    logic        read_error;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] read_block;
    logic [9:0]  word_index;
    logic [31:0] physical_block;
    logic [2:0]  status;
  } out_item_t;

  // Upper limits (exclusive) of the single, double and triple trees
  // in logical block numbers.
  typedef struct packed {
    logic [31:0] lim1;
    logic [31:0] lim2;
    logic [31:0] lim3;
  } tree_bounds_t;

  function automatic tree_bounds_t tree_bounds(input logic [1:0] v);
    tree_bounds_t b;
    logic [4:0]   s;
    logic [31:0]  p1;
    logic [31:0]  p2;
    logic [31:0]  p3;
    s  = 5'(PTR_SHIFT_BASE) + {3'b000, v};
    p1 = 32'd1 << s;
    p2 = 32'd1 << (s + s);
    p3 = 32'd1 << (s + s + s);
    b.lim1 = 32'(DIRECT_SLOTS) + p1;
    b.lim2 = b.lim1 + p2;
    b.lim3 = b.lim2 + p3;
    return b;
  endfunction

endpackage

// ----- hdl/indirect_block_map_walker.sv -----
// ----------------------------------------------------------------------------
// Indirect block map walker
// Translates file-relative block numbers into device block numbers through
// direct slots and single, double and triple indirect pointer trees.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                     Payload
//  -------  ---------  ----------------------------  -------------------------
//  in_      input      in_valid / in_stall           ibmw_pkg::in_item_t
//  out_     output     out_valid / out_stall         ibmw_pkg::out_item_t
//  cfg_     input      APB write/read, pready high   log_block_size at byte 0
//
//  One item is taken every cycle while in_stall is low; a result passes
//  through the input register, then the result register.
//  The walk state of one item is visible to the very next item, since both
//  the state and the result register are updated at the same edge.
//  A stalled result holds the result register; the staged input item then
//  waits and in_stall rises until the result register frees up.
//  Reset clears the slot table, the walk state, the setting and both valids.
//
// The block keeps one walk at a time. A translate item either answers at
// once (direct slot, null root, out of range, busy) or issues a read request
// for one pointer word. Each response item then descends one level: it ends
// the walk with the data block number, a null pointer or a read error, or it
// issues the next read request. The word index at each level is taken from
// the tree-relative offset by a shift of the remaining levels times the
// pointer shift, then masked to the pointers-per-block width.
// ----------------------------------------------------------------------------
module indirect_block_map_walker (
  input  logic                                clk,
  input  logic                                rst_n,
  // Item input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ibmw_pkg::in_item_t                  in_data,
  // Result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output ibmw_pkg::out_item_t                 out_data,
  // Configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ibmw_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ibmw_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ibmw_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  // Input stage
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  ibmw_pkg::in_item_t     s1_item_r;
  logic                   in_take;
  logic                   s1_adv;
  logic                   out_free;

  // Result stage
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  ibmw_pkg::out_item_t    out_item_r;

  // Architectural state
  logic [31:0]            slot_r [ibmw_pkg::NUM_SLOTS];
  logic                   busy_r;
  logic                   busy_nxt;
  logic [1:0]             lvl_r;
  logic [1:0]             lvl_nxt;
  logic [31:0]            off_r;
  logic [31:0]            off_nxt;
  logic [1:0]             lbs_r;

  // Work logic
  logic                   res_valid;
  ibmw_pkg::out_item_t    res_item;
  logic                   slot_we;
  logic [1:0]             v_eff;
  logic [3:0]             ptr_shift;
  ibmw_pkg::tree_bounds_t bounds;
  logic [31:0]            lb;
  logic                   is_direct;
  logic [1:0]             tree_lvl;
  logic [31:0]            tree_off;
  logic [ibmw_pkg::SLOT_IDX_W-1:0] root_idx;
  logic [ibmw_pkg::SLOT_IDX_W-1:0] rd_idx;
  logic [31:0]            slot_rd;
  logic                   cfg_wr;

  // Word index of the pointer wanted at a given number of remaining levels.
  function automatic logic [9:0] word_idx(input logic [31:0] off,
                                          input logic [1:0]  lvl,
                                          input logic [3:0]  s);
    logic [4:0]  sh;
    logic [31:0] shifted;
    logic [9:0]  mask;
    case (lvl)
      2'd0:    sh = 5'd0;
      2'd1:    sh = {1'b0, s};
      default: sh = {1'b0, s} + {1'b0, s};
    endcase
    shifted = off >> sh;
    mask    = (10'd1 << s) - 10'd1;
    return shifted[ibmw_pkg::WORD_IDX_W-1:0] & mask;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = res_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[ibmw_pkg::CFG_ADDR_W-1] == ibmw_pkg::REG_LOG_BLOCK_SIZE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[ibmw_pkg::CFG_ADDR_W-1] == ibmw_pkg::REG_LOG_BLOCK_SIZE) begin
      cfg_prdata = {{(ibmw_pkg::CFG_DATA_W-2){1'b0}}, lbs_r};
    end
  end

  // A setting of three behaves as two.
  assign v_eff     = (lbs_r > 2'(ibmw_pkg::LBS_MAX)) ? 2'(ibmw_pkg::LBS_MAX) : lbs_r;
  assign ptr_shift = 4'(ibmw_pkg::PTR_SHIFT_BASE) + {2'b00, v_eff};
  assign bounds    = ibmw_pkg::tree_bounds(v_eff);

  // --------------------------------------------------------------------------
  // Tree selection and slot read
  // --------------------------------------------------------------------------
  assign lb        = s1_item_r.logical_block;
  assign is_direct = lb < 32'(ibmw_pkg::DIRECT_SLOTS);

  always_comb begin
    if (lb < bounds.lim1) begin
      tree_lvl = 2'd0;
      tree_off = lb - 32'(ibmw_pkg::DIRECT_SLOTS);
      root_idx = ibmw_pkg::SLOT_IDX_W'(ibmw_pkg::SINGLE_SLOT);
    end else if (lb < bounds.lim2) begin
      tree_lvl = 2'd1;
      tree_off = lb - bounds.lim1;
      root_idx = ibmw_pkg::SLOT_IDX_W'(ibmw_pkg::DOUBLE_SLOT);
    end else begin
      tree_lvl = 2'd2;
      tree_off = lb - bounds.lim2;
      root_idx = ibmw_pkg::SLOT_IDX_W'(ibmw_pkg::TRIPLE_SLOT);
    end
  end

  assign rd_idx  = is_direct ? lb[ibmw_pkg::SLOT_IDX_W-1:0] : root_idx;
  assign slot_rd = (32'(rd_idx) < 32'(ibmw_pkg::NUM_SLOTS)) ? slot_r[rd_idx] : 32'd0;

  // --------------------------------------------------------------------------
  // One walk step per item
  // --------------------------------------------------------------------------
  always_comb begin
    res_valid = 1'b0;
    res_item  = '0;
    busy_nxt  = busy_r;
    lvl_nxt   = lvl_r;
    off_nxt   = off_r;
    slot_we   = 1'b0;
    case (s1_item_r.action)
      ibmw_pkg::ACT_LOAD_SLOT: begin
        slot_we = 32'(s1_item_r.slot_index) < 32'(ibmw_pkg::NUM_SLOTS);
      end
      ibmw_pkg::ACT_TRANSLATE: begin
        res_valid     = 1'b1;
        res_item.kind = ibmw_pkg::KIND_FINAL;
        if (busy_r) begin
          // The running walk carries on untouched.
          res_item.status = ibmw_pkg::ST_BUSY;
        end else if (is_direct) begin
          res_item.physical_block = slot_rd;
          res_item.status         = ibmw_pkg::ST_OK;
          lvl_nxt = 2'd0;
          off_nxt = '0;
        end else if (lb < bounds.lim3) begin
          if (slot_rd == 32'd0) begin
            res_item.status = ibmw_pkg::ST_NULL;
            lvl_nxt = 2'd0;
            off_nxt = '0;
          end else begin
            busy_nxt = 1'b1;
            lvl_nxt  = tree_lvl;
            off_nxt  = tree_off;
            res_item.kind       = ibmw_pkg::KIND_REQUEST;
            res_item.read_block = slot_rd;
            res_item.word_index = word_idx(tree_off, tree_lvl, ptr_shift);
            res_item.status     = ibmw_pkg::ST_OK;
          end
        end else begin
          res_item.status = ibmw_pkg::ST_RANGE;
          lvl_nxt = 2'd0;
          off_nxt = '0;
        end
      end
      ibmw_pkg::ACT_RESPONSE: begin
        // A response with no walk running is dropped.
        if (busy_r) begin
          res_valid     = 1'b1;
          res_item.kind = ibmw_pkg::KIND_FINAL;
          busy_nxt      = 1'b0;
          lvl_nxt       = 2'd0;
          off_nxt       = '0;
          if (s1_item_r.read_error) begin
            res_item.status = ibmw_pkg::ST_RDERR;
          end else if (lvl_r == 2'd0) begin
            // The data block itself; zero is a hole and still ok.
            res_item.physical_block = s1_item_r.pointer_value;
            res_item.status         = ibmw_pkg::ST_OK;
          end else if (s1_item_r.pointer_value == 32'd0) begin
            res_item.status = ibmw_pkg::ST_NULL;
          end else begin
            busy_nxt = 1'b1;
            lvl_nxt  = lvl_r - 2'd1;
            off_nxt  = off_r;
            res_item.kind       = ibmw_pkg::KIND_REQUEST;
            res_item.read_block = s1_item_r.pointer_value;
            res_item.word_index = word_idx(off_r, lvl_r - 2'd1, ptr_shift);
            res_item.status     = ibmw_pkg::ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      lvl_r       <= 2'd0;
      off_r       <= '0;
      lbs_r       <= 2'd0;
      for (int i = 0; i < ibmw_pkg::NUM_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        lbs_r <= cfg_pwdata[1:0];
      end
      if (s1_adv) begin
        busy_r <= busy_nxt;
        lvl_r  <= lvl_nxt;
        off_r  <= off_nxt;
        if (slot_we) begin
          slot_r[s1_item_r.slot_index[ibmw_pkg::SLOT_IDX_W-1:0]] <= s1_item_r.pointer_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_adv && res_valid) begin
      out_item_r <= res_item;
    end
  end

endmodule

// ----- hdl/ibmw_checker.sv -----
// ----------------------------------------------------------------------------
// Indirect block map walker checker
// Port-level properties of the walker's result channel.
// ----------------------------------------------------------------------------
module ibmw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input ibmw_pkg::out_item_t             out_data
);

  // A stalled result transfer keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A read request carries no translation and an ok status.
  a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == ibmw_pkg::KIND_REQUEST |->
      out_data.status == ibmw_pkg::ST_OK && out_data.physical_block == 32'd0)
    else $error("read request with answer fields set");

  // A final answer names no pointer word.
  a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == ibmw_pkg::KIND_FINAL |->
      out_data.read_block == 32'd0 && out_data.word_index == 10'd0)
    else $error("final answer with read fields set");

  // An error answer carries no block number.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == ibmw_pkg::KIND_FINAL &&
      out_data.status != ibmw_pkg::ST_OK |-> out_data.physical_block == 32'd0)
    else $error("error answer with block number");

endmodule

bind indirect_block_map_walker ibmw_checker u_ibmw_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indirect block map walker testbench
// Loads the pointer slot table and drives translate requests and pointer read
// responses under random idling on both channels. The testbench predicts each
// result from its own model of the walk and compares every field.
// ----------------------------------------------------------------------------
module tb;

  // The fourth action code has no meaning and the block must ignore it.
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam logic [ibmw_pkg::CFG_ADDR_W-1:0] LBS_ADDR =
    ibmw_pkg::CFG_ADDR_W'(4 * int'(ibmw_pkg::REG_LOG_BLOCK_SIZE));
  localparam int ITEMS_PER_PHASE = 270;
  localparam int NUM_PHASES      = 6;
  // Outlasts the two-stage pipeline, so that an item which gives no result
  // has surely left it before the setting is changed.
  localparam int SETTLE_CYCLES   = 4;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the slot table, the setting and the walk
  // state, works out the answer to every accepted item and compares results
  // in order against the answers still outstanding.
  // --------------------------------------------------------------------------
  class block_map_scoreboard;
    ibmw_pkg::out_item_t expected_answers[$];
    logic [31:0]         slots[ibmw_pkg::NUM_SLOTS];
    logic [1:0]          log_block_size;
    logic [1:0]          levels_left;
    logic [31:0]         tree_offset;
    bit                  walk_busy;
    int                  failures;

    function new();
      foreach (slots[i]) slots[i] = '0;
      log_block_size = '0;
      levels_left    = '0;
      tree_offset    = '0;
      walk_busy      = 1'b0;
      failures       = 0;
    endfunction

    function void set_block_size(logic [1:0] v);
      log_block_size = v;
    endfunction

    // A setting above the largest one behaves as the largest.
    function int ptr_shift();
      return ibmw_pkg::PTR_SHIFT_BASE +
             ((log_block_size > ibmw_pkg::LBS_MAX) ? ibmw_pkg::LBS_MAX
                                                   : int'(log_block_size));
    endfunction

    // Exclusive upper limit, in logical blocks, of the direct slots (level 0)
    // and of the single, double and triple trees (levels 1 to 3).
    function logic [63:0] region_end(int level);
      logic [63:0] p;
      logic [63:0] e;
      int          s;
      s = ptr_shift();
      p = 64'd1 << s;
      e = 64'(ibmw_pkg::DIRECT_SLOTS);
      for (int i = 1; i <= level; i++) e += p << ((i - 1) * s);
      return e;
    endfunction

    function void ask_word(logic [31:0] blk);
      ibmw_pkg::out_item_t r;
      int                  s;
      s = ptr_shift();
      r = '0;
      r.kind       = ibmw_pkg::KIND_REQUEST;
      r.read_block = blk;
      r.word_index = 10'((tree_offset >> (int'(levels_left) * s)) &
                         ((32'd1 << s) - 32'd1));
      r.status     = ibmw_pkg::ST_OK;
      expected_answers.push_back(r);
    endfunction

    function void end_walk(logic [31:0] pb, ibmw_pkg::status_t st);
      ibmw_pkg::out_item_t r;
      walk_busy   = 1'b0;
      levels_left = '0;
      tree_offset = '0;
      r = '0;
      r.kind           = ibmw_pkg::KIND_FINAL;
      r.status         = st;
      r.physical_block = (st == ibmw_pkg::ST_OK) ? pb : '0;
      expected_answers.push_back(r);
    endfunction

    function void begin_walk(int slot, logic [63:0] off, logic [1:0] lv);
      if (slots[slot] == '0) begin
        end_walk('0, ibmw_pkg::ST_NULL);
      end else begin
        walk_busy   = 1'b1;
        tree_offset = off[31:0];
        levels_left = lv;
        ask_word(slots[slot]);
      end
    endfunction

    function void note_item(ibmw_pkg::in_item_t it);
      logic [63:0]         lb;
      ibmw_pkg::out_item_t r;
      lb = 64'(it.logical_block);
      case (it.action)
        ibmw_pkg::ACT_LOAD_SLOT: begin
          if (it.slot_index < ibmw_pkg::NUM_SLOTS) slots[it.slot_index] = it.pointer_value;
        end
        ibmw_pkg::ACT_TRANSLATE: begin
          if (walk_busy) begin
            r = '0;
            r.kind   = ibmw_pkg::KIND_FINAL;
            r.status = ibmw_pkg::ST_BUSY;
            expected_answers.push_back(r);
          end else if (lb < region_end(0)) begin
            end_walk(slots[int'(lb)], ibmw_pkg::ST_OK);
          end else if (lb < region_end(1)) begin
            begin_walk(ibmw_pkg::SINGLE_SLOT, lb - region_end(0), 2'd0);
          end else if (lb < region_end(2)) begin
            begin_walk(ibmw_pkg::DOUBLE_SLOT, lb - region_end(1), 2'd1);
          end else if (lb < region_end(3)) begin
            begin_walk(ibmw_pkg::TRIPLE_SLOT, lb - region_end(2), 2'd2);
          end else begin
            end_walk('0, ibmw_pkg::ST_RANGE);
          end
        end
        ibmw_pkg::ACT_RESPONSE: begin
          if (walk_busy) begin
            if (it.read_error) begin
              end_walk('0, ibmw_pkg::ST_RDERR);
            end else if (levels_left == 2'd0) begin
              end_walk(it.pointer_value, ibmw_pkg::ST_OK);
            end else if (it.pointer_value == '0) begin
              end_walk('0, ibmw_pkg::ST_NULL);
            end else begin
              levels_left = levels_left - 2'd1;
              ask_word(it.pointer_value);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(ibmw_pkg::out_item_t got);
      ibmw_pkg::out_item_t want;
      if (expected_answers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result: kind=%0d rb=%h wi=%0d pb=%h st=%0d",
                   got.kind, got.read_block, got.word_index, got.physical_block,
                   got.status);
      end else begin
        want = expected_answers.pop_front();
        if (got.kind !== want.kind || got.read_block !== want.read_block ||
            got.word_index !== want.word_index ||
            got.physical_block !== want.physical_block ||
            got.status !== want.status) begin
          failures++;
          if (failures <= 10)
            $display({"Mismatch: expected kind=%0d rb=%h wi=%0d pb=%h st=%0d, ",
                      "got kind=%0d rb=%h wi=%0d pb=%h st=%0d"},
                     want.kind, want.read_block, want.word_index, want.physical_block,
                     want.status, got.kind, got.read_block, got.word_index,
                     got.physical_block, got.status);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input is known from time zero.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                logic_unused_guard;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ibmw_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ibmw_pkg::out_item_t out_data;

  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [ibmw_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [ibmw_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [ibmw_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // While set, neither side idles: a stretch of back-to-back transfers.
  bit steady_run = 1'b0;

  block_map_scoreboard sb;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  indirect_block_map_walker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Result side. Signals are read at the rising edge, so they carry the values
  // that held at that edge; a transfer is checked and the stall for the next
  // cycle is chosen at random, about a third of the time.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= !steady_run && ($urandom_range(99, 0) < 33);
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Offers one item after a random number of idle cycles and holds it until
  // the transfer; the scoreboard learns of it at the edge where it is taken.
  // The valid is left high so that a following item can go out at once.
  task automatic send_item(input ibmw_pkg::in_item_t it);
    while (!steady_run && $urandom_range(99, 0) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  function automatic ibmw_pkg::in_item_t make_item(logic [1:0] action, logic [31:0] lb,
                                                   logic [3:0] si, logic [31:0] pv,
                                                   logic re);
    ibmw_pkg::in_item_t it;
    it.action        = action;
    it.logical_block = lb;
    it.slot_index    = si;
    it.pointer_value = pv;
    it.read_error    = re;
    return it;
  endfunction

  // Picks a logical block from the direct slots, one of the three trees or
  // the range beyond them, often right on a boundary; now and then any value.
  function automatic logic [31:0] pick_logical_block();
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned r;
    int unsigned e;
    r = $urandom_range(9, 0);
    if (r == 9) return $urandom();
    if (r == 8) begin
      lo = sb.region_end(3);
      hi = 64'hFFFF_FFFF;
    end else begin
      lo = (r < 2) ? 64'd0 : sb.region_end(int'(r / 2) - 1);
      hi = sb.region_end(int'(r / 2)) - 64'd1;
    end
    e = $urandom_range(7, 0);
    if (e == 0) return lo[31:0];
    if (e == 1) return hi[31:0];
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  // Chooses the next item from the state of the walk. During a walk most
  // items are pointer words read back, so that walks reach the deep levels;
  // otherwise most are translations. The rest is noise: loads, translations
  // that find the walker busy, stray responses and the unused action code.
  task automatic send_random_item();
    ibmw_pkg::in_item_t it;
    int unsigned        r;
    it.action        = ibmw_pkg::ACT_TRANSLATE;
    it.logical_block = $urandom();
    it.slot_index    = 4'($urandom_range(15, 0));
    it.pointer_value = $urandom();
    it.read_error    = 1'($urandom_range(1, 0));
    r = $urandom_range(99, 0);
    if (sb.walk_busy) begin
      if (r < 78) begin
        it.action     = ibmw_pkg::ACT_RESPONSE;
        it.read_error = ($urandom_range(99, 0) < 7);
        if ($urandom_range(99, 0) < 9) it.pointer_value = '0;
      end else if (r < 88) begin
        it.action = ibmw_pkg::ACT_TRANSLATE;
      end else if (r < 95) begin
        it.action = ibmw_pkg::ACT_LOAD_SLOT;
      end else begin
        it.action = ACT_RESERVED;
      end
    end else begin
      if (r < 72) begin
        it.action        = ibmw_pkg::ACT_TRANSLATE;
        it.logical_block = pick_logical_block();
      end else if (r < 84) begin
        it.action = ibmw_pkg::ACT_LOAD_SLOT;
        if ($urandom_range(99, 0) < 10) it.pointer_value = '0;
      end else if (r < 93) begin
        it.action = ibmw_pkg::ACT_RESPONSE;
      end else begin
        it.action = ACT_RESERVED;
      end
    end
    send_item(it);
  endtask

  // Stops sending and waits for every outstanding answer, then lets the
  // pipeline settle so that no item is left in flight.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: a setup phase, then the access phase that ends when
  // the port is ready.
  task automatic write_block_size(input logic [1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LBS_ADDR;
    cfg_pwdata  <= ibmw_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_block_size(v);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    // The setting for each random phase: both extremes, the out-of-range
    // value that must behave as the largest, and a return to the default.
    logic [1:0] block_size_plan[NUM_PHASES];

    block_size_plan = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset setting of 256 pointers per block.
    // Fill the table: extreme values, the last direct slot, a write past the
    // end of the table and a null double-indirect root.
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'd0, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'(ibmw_pkg::DIRECT_SLOTS - 1),
                        32'h1234_5678, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'hF, 32'hDEAD_BEEF, 1'b1));
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'(ibmw_pkg::SINGLE_SLOT),
                        32'h0000_0100, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'(ibmw_pkg::DOUBLE_SLOT),
                        32'h0000_0000, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'(ibmw_pkg::TRIPLE_SLOT),
                        32'h8000_0300, 1'b0));
    // Direct answer, then a double-tree translation that meets the null root.
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'd0, 4'd0, 32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'(sb.region_end(1)), 4'd0, 32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_LOAD_SLOT, 32'd0, 4'(ibmw_pkg::DOUBLE_SLOT),
                        32'h0000_0200, 1'b0));
    // Single-tree walk: a translation while busy, then a hole as the data
    // block, then a response when no walk is in progress and the unused code.
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'(ibmw_pkg::DIRECT_SLOTS + 5), 4'd0,
                        32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'd0, 4'd0, 32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'h0000_0055, 1'b0));
    send_item(make_item(ACT_RESERVED, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b1));
    // Triple-tree walk that ends on a null pointer at its third level.
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'(sb.region_end(2)), 4'd0, 32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'h0000_0400, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'h0000_0000, 1'b0));
    // Double-tree walk cut short by a failed read.
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'(sb.region_end(1) + 64'd1000), 4'd0,
                        32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'h0000_0123, 1'b1));
    // Beyond every tree, then the very last triple-tree block all the way down.
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF, 4'd0, 32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_TRANSLATE, 32'(sb.region_end(3) - 64'd1), 4'd0,
                        32'd0, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'hFFFF_FFFF, 1'b0));
    send_item(make_item(ibmw_pkg::ACT_RESPONSE, 32'd0, 4'd0, 32'hFFFF_FFFF, 1'b0));
    wait_until_drained();

    // Random phases. Each ends on a triple-tree translation, so that the next
    // setting usually arrives in the middle of a walk and the remaining word
    // indices are taken with the new pointers-per-block value. The third
    // phase runs without any idling on either side.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_block_size(block_size_plan[ph]);
      steady_run = (ph == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_item();
      end
      send_item(make_item(ibmw_pkg::ACT_TRANSLATE,
                          32'(sb.region_end(2)) + $urandom_range(7, 0),
                          4'd0, 32'd0, 1'b0));
      wait_until_drained();
      steady_run = 1'b0;
    end

    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
